@@ sv/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// prc_pkg
// Types and constants shared by the page reference counter modules: the
// payload structures of the request and response words, command and status
// codes, and the fixed widths of the configuration registers.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int SLOT_MAX      = 4;
    localparam int CFG_INDEX_W   = 3;
    localparam int FRAME_BITS    = 44;
    localparam int PAGES_BITS    = 17;
    localparam int ADDR_BITS     = 56;
    localparam int CMD_BITS      = 2;
    localparam int NEWVAL_BITS   = 16;
    localparam int COUNT_OUT_W   = 16;
    localparam int STATUS_BITS   = 3;
    localparam int CMP_BITS      = 48;
    localparam int OFFSET_BITS   = 17;
    localparam int SUM_BITS      = 21;
    localparam int IDX_MAX_BITS  = 20;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = 2;
    localparam int PEND_BITS     = 3;

    localparam logic [CMD_BITS-1:0] CMD_GET = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_INC = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_DEC = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_SET = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD_ADDR   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_PAST_STORE = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_SATURATED  = 3'd4;

    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [PAGES_BITS-1:0] pages_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]    command;
        logic [ADDR_BITS-1:0]   phys_addr;
        logic [NEWVAL_BITS-1:0] new_value;
    } req_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic                   now_free;
        logic [STATUS_BITS-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]     command;
        logic [NEWVAL_BITS-1:0]  new_value;
        logic [STATUS_BITS-1:0]  status;
        logic [IDX_MAX_BITS-1:0] index;
    } job_t;

endpackage

@@ sv/prc_stream_if.sv @@
// ----------------------------------------------------------------------------
// prc_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface prc_stream_if #(
    parameter type T = logic
);

    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

@@ sv/prc_queue.sv @@
// ----------------------------------------------------------------------------
// prc_queue
// Small first-in first-out queue of classified jobs between the front end
// and the back end.
// ----------------------------------------------------------------------------
module prc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  prc_pkg::job_t push_job,
    input  logic          pop,
    output logic          not_empty,
    output prc_pkg::job_t head_job
);

    prc_pkg::job_t                        entry_reg [prc_pkg::QUEUE_DEPTH];
    logic [prc_pkg::QPTR_BITS-1:0]        wr_ptr_reg;
    logic [prc_pkg::QPTR_BITS-1:0]        wr_ptr_next;
    logic [prc_pkg::QPTR_BITS-1:0]        rd_ptr_reg;
    logic [prc_pkg::QPTR_BITS-1:0]        rd_ptr_next;
    logic [prc_pkg::PEND_BITS-1:0]        fill_reg;
    logic [prc_pkg::PEND_BITS-1:0]        fill_next;

    assign not_empty = (fill_reg != '0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + prc_pkg::PEND_BITS'(push) - prc_pkg::PEND_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ sv/prc_front.sv @@
// ----------------------------------------------------------------------------
// prc_front
// Front end: accepts request words, matches the page frame against every
// region in parallel, then picks the first matching region, forms the packed
// counter index and classifies the request before it enters the queue.
// ----------------------------------------------------------------------------
module prc_front #(
    parameter int STORE_PAGES  = 65536,
    parameter int PAGE_SHIFT   = 12,
    parameter int REGION_SLOTS = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clearing,
    input  logic            req_valid,
    input  prc_pkg::req_t   req_payload,
    output logic            req_ready,
    input  prc_pkg::frame_t base_frame [prc_pkg::SLOT_MAX],
    input  prc_pkg::pages_t region_pages [prc_pkg::SLOT_MAX],
    input  logic            pop,
    output logic            push,
    output prc_pkg::job_t   push_job
);

    logic                                accept;
    logic [prc_pkg::PEND_BITS-1:0]       pending_reg;
    logic [prc_pkg::PEND_BITS-1:0]       pending_next;

    logic [prc_pkg::CMP_BITS-1:0]        frame;
    logic [prc_pkg::SLOT_MAX-1:0]        hit_next;
    logic [prc_pkg::OFFSET_BITS-1:0]     offset_next [prc_pkg::SLOT_MAX];
    logic [prc_pkg::SUM_BITS-1:0]        start_next [prc_pkg::SLOT_MAX];
    logic [prc_pkg::CMP_BITS:0]          diff [prc_pkg::SLOT_MAX];

    logic                                s1_valid_reg;
    logic [prc_pkg::CMD_BITS-1:0]        s1_command_reg;
    logic [prc_pkg::NEWVAL_BITS-1:0]     s1_new_value_reg;
    logic                                s1_aligned_reg;
    logic [prc_pkg::SLOT_MAX-1:0]        s1_hit_reg;
    logic [prc_pkg::OFFSET_BITS-1:0]     s1_offset_reg [prc_pkg::SLOT_MAX];
    logic [prc_pkg::SUM_BITS-1:0]        s1_start_reg [prc_pkg::SLOT_MAX];

    logic                                found;
    logic [prc_pkg::SUM_BITS-1:0]        sel_start;
    logic [prc_pkg::OFFSET_BITS-1:0]     sel_offset;
    logic [prc_pkg::SUM_BITS-1:0]        index_sum;

    assign req_ready = !clearing && (pending_reg < prc_pkg::PEND_BITS'(prc_pkg::QUEUE_DEPTH));
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        pending_next = pending_reg + prc_pkg::PEND_BITS'(accept) - prc_pkg::PEND_BITS'(pop);
    end

    always_comb
    begin
        frame = prc_pkg::CMP_BITS'(req_payload.phys_addr >> PAGE_SHIFT);
        for (int r = 0; r < prc_pkg::SLOT_MAX; r++)
        begin
            diff[r] = {1'b0, frame} - {1'b0, prc_pkg::CMP_BITS'(base_frame[r])};
            hit_next[r] = (r < REGION_SLOTS) && (region_pages[r] != '0) &&
                          !diff[r][prc_pkg::CMP_BITS] &&
                          (diff[r][prc_pkg::CMP_BITS-1:0] <
                           prc_pkg::CMP_BITS'(region_pages[r]));
            offset_next[r] = diff[r][prc_pkg::OFFSET_BITS-1:0];
            if (r == 0)
            begin
                start_next[r] = '0;
            end
            else
            begin
                start_next[r] = start_next[r-1] + prc_pkg::SUM_BITS'(region_pages[r-1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg  <= pending_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_command_reg   <= req_payload.command;
            s1_new_value_reg <= req_payload.new_value;
            s1_aligned_reg   <= (req_payload.phys_addr[PAGE_SHIFT-1:0] == '0);
            s1_hit_reg       <= hit_next;
            s1_offset_reg    <= offset_next;
            s1_start_reg     <= start_next;
        end
    end

    always_comb
    begin
        found      = 1'b0;
        sel_start  = '0;
        sel_offset = '0;
        for (int r = 0; r < prc_pkg::SLOT_MAX; r++)
        begin
            if (!found && s1_hit_reg[r])
            begin
                found      = 1'b1;
                sel_start  = s1_start_reg[r];
                sel_offset = s1_offset_reg[r];
            end
        end
        index_sum = sel_start + prc_pkg::SUM_BITS'(sel_offset);

        push_job.command   = s1_command_reg;
        push_job.new_value = s1_new_value_reg;
        push_job.index     = index_sum[prc_pkg::IDX_MAX_BITS-1:0];
        priority if (!found || !s1_aligned_reg)
        begin
            push_job.status = prc_pkg::ST_BAD_ADDR;
        end
        else if (index_sum >= prc_pkg::SUM_BITS'(STORE_PAGES))
        begin
            push_job.status = prc_pkg::ST_PAST_STORE;
        end
        else
        begin
            push_job.status = prc_pkg::ST_OK;
        end
    end

    assign push = s1_valid_reg;

endmodule

@@ sv/prc_back.sv @@
// ----------------------------------------------------------------------------
// prc_back
// Back end: owns the counter memory. Clears it after reset, then reads the
// counter of each queued job, applies the command, writes the counter back
// and loads the response into the output register.
// ----------------------------------------------------------------------------
module prc_back #(
    parameter int STORE_PAGES = 65536,
    parameter int COUNT_BITS  = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    output logic          clearing,
    input  logic          job_valid,
    input  prc_pkg::job_t job,
    output logic          job_pop,
    output logic          rsp_valid,
    output prc_pkg::rsp_t rsp_payload,
    input  logic          rsp_ready
);

    localparam int IDX_W = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
    localparam int WIDE  = (COUNT_BITS > prc_pkg::COUNT_OUT_W) ? COUNT_BITS
                                                               : prc_pkg::COUNT_OUT_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(STORE_PAGES - 1);

    logic [COUNT_BITS-1:0]           mem [STORE_PAGES];
    logic [COUNT_BITS-1:0]           rd_data_reg;

    logic                            clear_reg;
    logic                            clear_next;
    logic [IDX_W-1:0]                clr_idx_reg;
    logic [IDX_W-1:0]                clr_idx_next;
    logic                            op_valid_reg;
    logic                            op_valid_next;
    prc_pkg::job_t                   op_reg;
    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    prc_pkg::rsp_t                   rsp_reg;

    logic                            issue;
    logic                            finish;
    logic                            wr_en;
    logic [COUNT_BITS-1:0]           wr_data;
    logic [WIDE-1:0]                 cnt_w;
    logic [WIDE-1:0]                 nv_w;
    logic                            freed;
    logic [prc_pkg::STATUS_BITS-1:0] status;

    assign clearing    = clear_reg;
    assign issue       = job_valid && !op_valid_reg && !clear_reg;
    assign job_pop     = issue;
    assign finish      = op_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid   = rsp_valid_reg;
    assign rsp_payload = rsp_reg;

    always_comb
    begin
        nv_w    = WIDE'(op_reg.new_value);
        cnt_w   = '0;
        freed   = 1'b0;
        status  = op_reg.status;
        wr_en   = 1'b0;
        wr_data = rd_data_reg;
        if (op_reg.status == prc_pkg::ST_OK)
        begin
            unique case (op_reg.command)
                prc_pkg::CMD_GET:
                begin
                    cnt_w = WIDE'(rd_data_reg);
                end
                prc_pkg::CMD_INC:
                begin
                    wr_en = 1'b1;
                    if (rd_data_reg == CNT_MAX)
                    begin
                        wr_data = CNT_MAX;
                        status  = prc_pkg::ST_SATURATED;
                    end
                    else
                    begin
                        wr_data = rd_data_reg + 1'b1;
                    end
                    cnt_w = WIDE'(wr_data);
                end
                prc_pkg::CMD_DEC:
                begin
                    if (rd_data_reg == '0)
                    begin
                        status = prc_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data_reg - 1'b1;
                        freed   = (wr_data == '0);
                        cnt_w   = WIDE'(wr_data);
                    end
                end
                prc_pkg::CMD_SET:
                begin
                    wr_en = 1'b1;
                    if (nv_w > WIDE'(CNT_MAX))
                    begin
                        wr_data = CNT_MAX;
                        status  = prc_pkg::ST_SATURATED;
                    end
                    else
                    begin
                        wr_data = COUNT_BITS'(nv_w);
                    end
                    cnt_w = WIDE'(wr_data);
                end
                default:
                begin
                    cnt_w = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        clear_next     = clear_reg && (clr_idx_reg != LAST_IDX);
        clr_idx_next   = clear_reg ? clr_idx_reg + 1'b1 : clr_idx_reg;
        op_valid_next  = issue || (op_valid_reg && !finish);
        rsp_valid_next = finish || (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_idx_reg   <= '0;
            op_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clr_idx_reg   <= clr_idx_next;
            op_valid_reg  <= op_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            op_reg <= job;
        end
        if (finish)
        begin
            rsp_reg.count    <= cnt_w[prc_pkg::COUNT_OUT_W-1:0];
            rsp_reg.now_free <= freed;
            rsp_reg.status   <= status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (finish && wr_en)
        begin
            mem[op_reg.index[IDX_W-1:0]] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[job.index[IDX_W-1:0]];
        end
    end

endmodule

@@ sv/page_reference_counter_unit.sv @@
// ----------------------------------------------------------------------------
// page_reference_counter_unit
// Reference count per physical RAM page, for up to four configured regions.
//
// The req channel takes one word per access: a command (get, increment,
// decrement or set), a physical byte address and a value for set. The rsp
// channel returns exactly one word per access, in order: the count after the
// operation, a flag set when a decrement reached zero, and a status code.
// Region base frames and page counts are written through the cfg_we,
// cfg_index and cfg_wdata port, and should only change while no access is
// in flight.
// A request passes through the front-end stage register, the queue, the
// back-end operation register and the output register. The back end reads a
// counter and writes it back before reading the next, so it takes no new
// access until the last is done. After reset the region registers are zero;
// the counter memory is cleared one entry a cycle while req.ready stays low.
// When the receiver stalls, the response waits in the output register and
// the front end keeps taking requests until four are held in its stage and
// queue, after which req.ready drops.
// ----------------------------------------------------------------------------
module page_reference_counter_unit #(
    parameter int STORE_PAGES  = 65536,
    parameter int PAGE_SHIFT   = 12,
    parameter int COUNT_BITS   = 16,
    parameter int REGION_SLOTS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    prc_stream_if.sink                        req,
    prc_stream_if.source                      rsp,
    input  logic                              cfg_we,
    input  logic [prc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [prc_pkg::FRAME_BITS-1:0]    cfg_wdata
);

    prc_pkg::frame_t base_frame_reg [prc_pkg::SLOT_MAX];
    prc_pkg::pages_t region_pages_reg [prc_pkg::SLOT_MAX];

    logic            clearing;
    logic            push;
    logic            pop;
    logic            job_valid;
    prc_pkg::job_t   push_job;
    prc_pkg::job_t   head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < prc_pkg::SLOT_MAX; s++)
            begin
                base_frame_reg[s]   <= '0;
                region_pages_reg[s] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (!cfg_index[0])
            begin
                base_frame_reg[cfg_index[prc_pkg::CFG_INDEX_W-1:1]] <= cfg_wdata;
            end
            else
            begin
                region_pages_reg[cfg_index[prc_pkg::CFG_INDEX_W-1:1]] <=
                    cfg_wdata[prc_pkg::PAGES_BITS-1:0];
            end
        end
    end

    prc_front #(
        .STORE_PAGES  (STORE_PAGES),
        .PAGE_SHIFT   (PAGE_SHIFT),
        .REGION_SLOTS (REGION_SLOTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .clearing     (clearing),
        .req_valid    (req.valid),
        .req_payload  (req.payload),
        .req_ready    (req.ready),
        .base_frame   (base_frame_reg),
        .region_pages (region_pages_reg),
        .pop          (pop),
        .push         (push),
        .push_job     (push_job)
    );

    prc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .not_empty (job_valid),
        .head_job  (head_job)
    );

    prc_back #(
        .STORE_PAGES (STORE_PAGES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .clearing    (clearing),
        .job_valid   (job_valid),
        .job         (head_job),
        .job_pop     (pop),
        .rsp_valid   (rsp.valid),
        .rsp_payload (rsp.payload),
        .rsp_ready   (rsp.ready)
    );

endmodule

@@ sv/prc_checker.sv @@
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks for the page reference counter, attached to the top
// level by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
module prc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input prc_pkg::rsp_t rsp_payload
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("response word changed or dropped while stalled");

    a_clear_blocks: assert property (@(posedge clk)
        !rst_n |=> !req_ready)
        else $error("request accepted before the counter memory was cleared");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_payload.status == prc_pkg::ST_BAD_ADDR ||
                      rsp_payload.status == prc_pkg::ST_UNDERFLOW ||
                      rsp_payload.status == prc_pkg::ST_PAST_STORE)
        |-> rsp_payload.count == '0 && !rsp_payload.now_free)
        else $error("failed access reported a count or a free page");

    a_free_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.now_free
        |-> rsp_payload.count == '0 && rsp_payload.status == prc_pkg::ST_OK)
        else $error("free page reported with a nonzero count or an error");

endmodule

bind page_reference_counter_unit prc_checker u_prc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
